[design/lim_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lim_pkg: shared types and constants of the layout index map
// Widths, layout and dimension codes, the lane record and the order table.
// ----------------------------------------------------------------------------
package lim_pkg;

    localparam int FLAT_W      = 34;
    localparam int CNT_W       = 11;
    localparam int SPC_W       = 5;
    localparam int IDX_W       = 3;
    localparam int MAX_DIM     = 1024;
    localparam int MAX_SPECIES = 16;
    localparam int GROUPS      = 4;
    localparam int CELLS       = GROUPS * FLAT_W;

    typedef enum logic [2:0] {
        LAYOUT_YXMS = 3'd0,
        LAYOUT_XYMS = 3'd1,
        LAYOUT_XMYS = 3'd2,
        LAYOUT_YMXS = 3'd3,
        LAYOUT_MXYS = 3'd4,
        LAYOUT_MYXS = 3'd5
    } layout_t;

    typedef enum logic [IDX_W-1:0] {
        REG_LAYOUT  = 3'd0,
        REG_LOWER   = 3'd1,
        REG_COUNT_Y = 3'd2,
        REG_COUNT_X = 3'd3,
        REG_COUNT_M = 3'd4,
        REG_COUNT_S = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIM_Y  = 2'd0,
        DIM_X  = 2'd1,
        DIM_MU = 2'd2
    } dim_t;

    // Effective configuration as seen by the cell chain
    typedef struct packed {
        layout_t                layout;
        logic [FLAT_W-1:0]      lower;
        logic [CNT_W-1:0]       n_y;
        logic [CNT_W-1:0]       n_x;
        logic [CNT_W-1:0]       n_mu;
        logic [SPC_W-1:0]       n_s;
    } cfg_t;

    // One transaction in flight along the chain
    typedef struct packed {
        logic                   valid;
        logic [CNT_W-1:0]       rem;
        logic [FLAT_W-1:0]      quo;
        logic [CNT_W-1:0]       dig_y;
        logic [CNT_W-1:0]       dig_mu;
        logic [FLAT_W-1:0]      acc;
        logic [CNT_W-1:0]       coord_y;
        logic [CNT_W-1:0]       coord_x;
        logic [CNT_W-1:0]       coord_mu;
    } lane_t;

    // Dimension at position k (fastest first) of a layout
    function automatic dim_t order_dim(layout_t l, logic [1:0] k);
        dim_t d;
        d = DIM_Y;
        unique case (l)
            LAYOUT_YXMS: d = (k == 2'd0) ? DIM_Y  : (k == 2'd1) ? DIM_X  : DIM_MU;
            LAYOUT_XYMS: d = (k == 2'd0) ? DIM_X  : (k == 2'd1) ? DIM_Y  : DIM_MU;
            LAYOUT_XMYS: d = (k == 2'd0) ? DIM_X  : (k == 2'd1) ? DIM_MU : DIM_Y;
            LAYOUT_YMXS: d = (k == 2'd0) ? DIM_Y  : (k == 2'd1) ? DIM_MU : DIM_X;
            LAYOUT_MXYS: d = (k == 2'd0) ? DIM_MU : (k == 2'd1) ? DIM_X  : DIM_Y;
            LAYOUT_MYXS: d = (k == 2'd0) ? DIM_MU : (k == 2'd1) ? DIM_Y  : DIM_X;
            default:     d = (k == 2'd0) ? DIM_Y  : (k == 2'd1) ? DIM_X  : DIM_MU;
        endcase
        return d;
    endfunction

    // Size of one dimension
    function automatic logic [CNT_W-1:0] dim_count(cfg_t c, dim_t d);
        logic [CNT_W-1:0] n;
        n = c.n_y;
        unique case (d)
            DIM_Y:   n = c.n_y;
            DIM_X:   n = c.n_x;
            DIM_MU:  n = c.n_mu;
            default: n = c.n_y;
        endcase
        return n;
    endfunction

endpackage

[design/lim_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lim_cfg: configuration registers
// Holds the six registers and presents their effective (clamped) values.
// ----------------------------------------------------------------------------
module lim_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [lim_pkg::IDX_W-1:0]     wr_index,
    input  logic [lim_pkg::FLAT_W-1:0]    wr_data,
    output lim_pkg::cfg_t                 cfg
);

    lim_pkg::layout_t                   layout_reg;
    logic [lim_pkg::FLAT_W-1:0]         lower_reg;
    logic [lim_pkg::CNT_W-1:0]          count_y_reg;
    logic [lim_pkg::CNT_W-1:0]          count_x_reg;
    logic [lim_pkg::CNT_W-1:0]          count_mu_reg;
    logic [lim_pkg::SPC_W-1:0]          count_s_reg;

    function automatic logic [lim_pkg::CNT_W-1:0] clamp_dim(logic [lim_pkg::CNT_W-1:0] n);
        logic [lim_pkg::CNT_W-1:0] r;
        r = n;
        if (n == '0)
            r = lim_pkg::CNT_W'(1);
        else if (n > lim_pkg::CNT_W'(lim_pkg::MAX_DIM))
            r = lim_pkg::CNT_W'(lim_pkg::MAX_DIM);
        return r;
    endfunction

    function automatic logic [lim_pkg::SPC_W-1:0] clamp_spc(logic [lim_pkg::SPC_W-1:0] n);
        logic [lim_pkg::SPC_W-1:0] r;
        r = n;
        if (n == '0)
            r = lim_pkg::SPC_W'(1);
        else if (n > lim_pkg::SPC_W'(lim_pkg::MAX_SPECIES))
            r = lim_pkg::SPC_W'(lim_pkg::MAX_SPECIES);
        return r;
    endfunction

    // Write a register; drop unknown layouts and unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg   <= lim_pkg::LAYOUT_YXMS;
            lower_reg    <= '0;
            count_y_reg  <= lim_pkg::CNT_W'(1);
            count_x_reg  <= lim_pkg::CNT_W'(1);
            count_mu_reg <= lim_pkg::CNT_W'(1);
            count_s_reg  <= lim_pkg::SPC_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                lim_pkg::REG_LAYOUT:
                begin
                    if (wr_data[2:0] < 3'd6)
                        layout_reg <= lim_pkg::layout_t'(wr_data[2:0]);
                end
                lim_pkg::REG_LOWER:   lower_reg    <= wr_data;
                lim_pkg::REG_COUNT_Y: count_y_reg  <= wr_data[lim_pkg::CNT_W-1:0];
                lim_pkg::REG_COUNT_X: count_x_reg  <= wr_data[lim_pkg::CNT_W-1:0];
                lim_pkg::REG_COUNT_M: count_mu_reg <= wr_data[lim_pkg::CNT_W-1:0];
                lim_pkg::REG_COUNT_S: count_s_reg  <= wr_data[lim_pkg::SPC_W-1:0];
                default: ;
            endcase
        end
    end

    // Present effective values
    always_comb
    begin
        cfg.layout = layout_reg;
        cfg.lower  = lower_reg;
        cfg.n_y    = clamp_dim(count_y_reg);
        cfg.n_x    = clamp_dim(count_x_reg);
        cfg.n_mu   = clamp_dim(count_mu_reg);
        cfg.n_s    = clamp_spc(count_s_reg);
    end

endmodule

[design/lim_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lim_cell: one cell of the index chain
// One restoring division step on the lane, plus an optional Horner step.
// ----------------------------------------------------------------------------
module lim_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  lim_pkg::lane_t                lane_in,
    input  logic [lim_pkg::CNT_W-1:0]     divisor,
    input  logic                          horner_en,
    input  logic [lim_pkg::CNT_W-1:0]     coord,
    input  logic [lim_pkg::CNT_W-1:0]     mult,
    output lim_pkg::lane_t                lane_out
);

    logic                                 valid_reg;
    lim_pkg::lane_t                       data_reg;
    lim_pkg::lane_t                       data_next;
    logic [lim_pkg::CNT_W:0]              trial;
    logic                                 fits;
    logic [lim_pkg::FLAT_W-1:0]           prod;

    // Shift in the next dividend bit and subtract where the divisor fits
    always_comb
    begin
        trial     = {lane_in.rem, lane_in.quo[lim_pkg::FLAT_W-1]};
        fits      = (trial >= {1'b0, divisor});
        prod      = lim_pkg::FLAT_W'(lane_in.acc * {{(lim_pkg::FLAT_W-lim_pkg::CNT_W){1'b0}}, mult});
        data_next = lane_in;
        data_next.rem = fits ? lim_pkg::CNT_W'(trial - {1'b0, divisor})
                             : trial[lim_pkg::CNT_W-1:0];
        data_next.quo = {lane_in.quo[lim_pkg::FLAT_W-2:0], fits};
        if (horner_en)
            data_next.acc = ({{(lim_pkg::FLAT_W-lim_pkg::CNT_W){1'b0}}, coord}
                             - lim_pkg::FLAT_W'(1)) + prod;
    end

    // Clear valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= lane_in.valid;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (advance)
            data_reg <= data_next;
    end

    always_comb
    begin
        lane_out       = data_reg;
        lane_out.valid = valid_reg;
    end

endmodule

[design/layout_index_map_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layout_index_map_unit: flat index to coordinates and back
// Mixed-radix decomposition and composition over six dimension orders.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  in      | in_valid/in_ready, flat_index, coordinates    | to block
//  out     | out_valid/out_ready, *_of_flat, flat_of_coords| from block
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | to block
//
//  A chain of 136 cells, one restoring division step each (34 per digit,
//  four digits), takes one transaction per cycle while out is not stalled.
//  The first three cells also do the three Horner steps of the composition.
//  The last cell is the output register; a stall on out holds the whole
//  chain, and in_ready follows it. Reset clears the valid bits and the
//  registers to their defaults; cfg_ready is always high.
// ----------------------------------------------------------------------------
module layout_index_map_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [33:0]                   flat_index,
    input  logic [10:0]                   y_mode,
    input  logic [10:0]                   x_mode,
    input  logic [10:0]                   mu_index,
    input  logic [4:0]                    species_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [10:0]                   y_of_flat,
    output logic [10:0]                   mu_of_flat,
    output logic [4:0]                    species_of_flat,
    output logic [33:0]                   flat_of_coords,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [33:0]                   cfg_data
);

    lim_pkg::cfg_t                        cfg;
    lim_pkg::lane_t                       entry;
    lim_pkg::lane_t                       cell_in  [lim_pkg::CELLS];
    lim_pkg::lane_t                       cell_out [lim_pkg::CELLS];
    lim_pkg::lane_t                       last;
    logic                                 advance;

    assign cfg_ready = 1'b1;

    lim_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move the chain when the output is free or being taken
    assign last     = cell_out[lim_pkg::CELLS-1];
    assign advance  = !last.valid || out_ready;
    assign in_ready = advance;

    // Build the entering lane
    always_comb
    begin
        entry          = '0;
        entry.valid    = in_valid;
        entry.quo      = flat_index - cfg.lower;
        entry.acc      = {{(lim_pkg::FLAT_W-lim_pkg::SPC_W){1'b0}}, species_index}
                         - lim_pkg::FLAT_W'(1);
        entry.coord_y  = y_mode;
        entry.coord_x  = x_mode;
        entry.coord_mu = mu_index;
    end

    for (genvar i = 0; i < lim_pkg::CELLS; i++)
    begin : g_cell
        localparam int GRP = i / lim_pkg::FLAT_W;
        logic [lim_pkg::CNT_W-1:0]        div_sel;
        logic [lim_pkg::CNT_W-1:0]        coord_sel;
        logic [lim_pkg::CNT_W-1:0]        mult_sel;
        logic                             horner;

        // Link to the previous cell; store a finished y or mu digit at a group start
        if (i == 0)
        begin : g_head
            assign cell_in[i] = entry;
        end
        else if ((i % lim_pkg::FLAT_W) == 0)
        begin : g_bound
            lim_pkg::dim_t done_dim;
            assign done_dim = lim_pkg::order_dim(cfg.layout, 2'(GRP - 1));
            always_comb
            begin
                cell_in[i]     = cell_out[i-1];
                cell_in[i].rem = '0;
                unique case (done_dim)
                    lim_pkg::DIM_Y:  cell_in[i].dig_y  = cell_out[i-1].rem;
                    lim_pkg::DIM_MU: cell_in[i].dig_mu = cell_out[i-1].rem;
                    default: ;
                endcase
            end
        end
        else
        begin : g_pass
            assign cell_in[i] = cell_out[i-1];
        end

        // Pick the divisor of this cell's digit
        if (GRP < 3)
        begin : g_div_dim
            assign div_sel = lim_pkg::dim_count(cfg,
                                 lim_pkg::order_dim(cfg.layout, 2'(GRP)));
        end
        else
        begin : g_div_spc
            assign div_sel = {{(lim_pkg::CNT_W-lim_pkg::SPC_W){1'b0}}, cfg.n_s};
        end

        // Horner step from the slowest dimension down
        if (i < 3)
        begin : g_horner
            lim_pkg::dim_t h_dim;
            assign h_dim    = lim_pkg::order_dim(cfg.layout, 2'(2 - i));
            assign horner   = 1'b1;
            assign mult_sel = lim_pkg::dim_count(cfg, h_dim);
            always_comb
            begin
                unique case (h_dim)
                    lim_pkg::DIM_Y:  coord_sel = cell_in[i].coord_y;
                    lim_pkg::DIM_X:  coord_sel = cell_in[i].coord_x;
                    lim_pkg::DIM_MU: coord_sel = cell_in[i].coord_mu;
                    default:         coord_sel = cell_in[i].coord_y;
                endcase
            end
        end
        else
        begin : g_no_horner
            assign horner    = 1'b0;
            assign mult_sel  = '0;
            assign coord_sel = '0;
        end

        lim_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .lane_in   (cell_in[i]),
            .divisor   (div_sel),
            .horner_en (horner),
            .coord     (coord_sel),
            .mult      (mult_sel),
            .lane_out  (cell_out[i])
        );
    end

    // Present the result
    assign out_valid       = last.valid;
    assign y_of_flat       = last.dig_y + lim_pkg::CNT_W'(1);
    assign mu_of_flat      = last.dig_mu + lim_pkg::CNT_W'(1);
    assign species_of_flat = last.rem[lim_pkg::SPC_W-1:0] + lim_pkg::SPC_W'(1);
    assign flat_of_coords  = last.acc;

    // Checks
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready out of step with output stall");

    a_species_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (species_of_flat != '0 && species_of_flat <= 5'd16))
        else $error("species coordinate out of range");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (y_of_flat != '0 && y_of_flat <= 11'd1024))
        else $error("y coordinate out of range");

    a_layout_known: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == lim_pkg::REG_LAYOUT
        && cfg_data[2:0] > lim_pkg::LAYOUT_MYXS
        |=> $stable(cfg.layout))
        else $error("unknown layout was taken");

endmodule

[sim/tb_layout_index_map_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_layout_index_map_unit: self-checking bench for the layout index map
// Walks a directed table, then random transactions over several register
// settings and idling phases; each result is checked against a typed-in value or a predictor.
// ----------------------------------------------------------------------------
module tb_layout_index_map_unit;

    localparam int  LATENCY     = 136;
    localparam int  N_RANDOM    = 750;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [33:0] flat;
        logic [10:0] y;
        logic [10:0] x;
        logic [10:0] mu;
        logic [4:0]  sp;
    } coord_in_t;

    typedef struct {
        logic [10:0] y;
        logic [10:0] mu;
        logic [4:0]  sp;
        logic [33:0] flat;
    } coord_out_t;

    // Directed row: stimulus plus an optional typed-in result
    typedef struct {
        coord_in_t  stim;
        bit         typed;
        coord_out_t want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [33:0] flat_index = '0;
    logic [10:0] y_mode = '0;
    logic [10:0] x_mode = '0;
    logic [10:0] mu_index = '0;
    logic [4:0]  species_index = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [10:0] y_of_flat;
    logic [10:0] mu_of_flat;
    logic [4:0]  species_of_flat;
    logic [33:0] flat_of_coords;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [33:0] cfg_data = '0;

    // Predictor copy of the registers
    lim_pkg::layout_t mdl_layout;
    logic [33:0] mdl_lower;
    logic [10:0] mdl_ny, mdl_nx, mdl_nmu;
    logic [4:0]  mdl_ns;

    coord_out_t  expected_q[$];
    int          fail_count = 0;
    int          send_idle = 0;
    int          recv_stall = 0;
    longint      cycle_count = 0;
    dir_row_t    dir_rows[$];

    layout_index_map_unit DUT (.*);

    always #4 clk = ~clk;

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic longint unsigned clamp_count(longint unsigned n,
                                                    longint unsigned top);
        if (n == 0)
            return 1;
        if (n > top)
            return top;
        return n;
    endfunction

    // Dimension sizes indexed y, x, mu
    function automatic longint unsigned size_of(lim_pkg::dim_t d);
        case (d)
            lim_pkg::DIM_Y:   return clamp_count(mdl_ny, lim_pkg::MAX_DIM);
            lim_pkg::DIM_X:   return clamp_count(mdl_nx, lim_pkg::MAX_DIM);
            default:          return clamp_count(mdl_nmu, lim_pkg::MAX_DIM);
        endcase
    endfunction

    function automatic lim_pkg::dim_t dim_at(int k);
        case (mdl_layout)
            lim_pkg::LAYOUT_XYMS:
                return (k == 0) ? lim_pkg::DIM_X  : (k == 1) ? lim_pkg::DIM_Y  : lim_pkg::DIM_MU;
            lim_pkg::LAYOUT_XMYS:
                return (k == 0) ? lim_pkg::DIM_X  : (k == 1) ? lim_pkg::DIM_MU : lim_pkg::DIM_Y;
            lim_pkg::LAYOUT_YMXS:
                return (k == 0) ? lim_pkg::DIM_Y  : (k == 1) ? lim_pkg::DIM_MU : lim_pkg::DIM_X;
            lim_pkg::LAYOUT_MXYS:
                return (k == 0) ? lim_pkg::DIM_MU : (k == 1) ? lim_pkg::DIM_X  : lim_pkg::DIM_Y;
            lim_pkg::LAYOUT_MYXS:
                return (k == 0) ? lim_pkg::DIM_MU : (k == 1) ? lim_pkg::DIM_Y  : lim_pkg::DIM_X;
            default:
                return (k == 0) ? lim_pkg::DIM_Y  : (k == 1) ? lim_pkg::DIM_X  : lim_pkg::DIM_MU;
        endcase
    endfunction

    // Split the flat index and compose the coordinates
    function automatic coord_out_t map_coords(coord_in_t c);
        coord_out_t      r;
        longint unsigned q, sum, n, ns;
        longint unsigned digit[3];
        longint unsigned crd[3];
        lim_pkg::dim_t   d;
        ns = clamp_count(mdl_ns, lim_pkg::MAX_SPECIES);
        q = (longint'(c.flat) - longint'(mdl_lower)) & 64'h3_FFFF_FFFF;
        for (int k = 0; k < 3; k++)
        begin
            d = dim_at(k);
            n = size_of(d);
            digit[d] = q % n;
            q = q / n;
        end
        r.y  = 11'(digit[lim_pkg::DIM_Y] + 1);
        r.mu = 11'(digit[lim_pkg::DIM_MU] + 1);
        r.sp = 5'((q % ns) + 1);
        crd[lim_pkg::DIM_Y]  = c.y;
        crd[lim_pkg::DIM_X]  = c.x;
        crd[lim_pkg::DIM_MU] = c.mu;
        sum = longint'(c.sp) - 1;
        for (int k = 2; k >= 0; k--)
        begin
            d = dim_at(k);
            sum = (crd[d] - 1) + size_of(d) * sum;
        end
        r.flat = 34'(sum);
        return r;
    endfunction

    // Present one register write; the caller drops cfg_valid afterwards
    task automatic write_reg(lim_pkg::cfg_reg_t idx, logic [33:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            lim_pkg::REG_LAYOUT:
                if (data[2:0] < 3'd6) mdl_layout = lim_pkg::layout_t'(data[2:0]);
            lim_pkg::REG_LOWER:   mdl_lower = data;
            lim_pkg::REG_COUNT_Y: mdl_ny = data[10:0];
            lim_pkg::REG_COUNT_X: mdl_nx = data[10:0];
            lim_pkg::REG_COUNT_M: mdl_nmu = data[10:0];
            lim_pkg::REG_COUNT_S: mdl_ns = data[4:0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [2:0] lay, logic [33:0] lo, logic [10:0] ny,
                             logic [10:0] nx, logic [10:0] nm, logic [4:0] ns);
        write_reg(lim_pkg::REG_LAYOUT, 34'(lay));
        write_reg(lim_pkg::REG_LOWER, lo);
        write_reg(lim_pkg::REG_COUNT_Y, 34'(ny));
        write_reg(lim_pkg::REG_COUNT_X, 34'(nx));
        write_reg(lim_pkg::REG_COUNT_M, 34'(nm));
        write_reg(lim_pkg::REG_COUNT_S, 34'(ns));
        cfg_valid <= 1'b0;
    endtask

    // Send one transaction, queueing its expected result; valid drops only to idle
    task automatic send_coords(coord_in_t c, bit typed, coord_out_t want);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        flat_index    <= c.flat;
        y_mode        <= c.y;
        x_mode        <= c.x;
        mu_index      <= c.mu;
        species_index <= c.sp;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(typed ? want : map_coords(c));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    // Accept results and compare with the oldest expectation
    always @(posedge clk)
    begin
        coord_out_t e;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (y_of_flat !== e.y)
                    begin
                        $error("y_of_flat exp %0d got %0d", e.y, y_of_flat);
                        fail_count++;
                    end
                    if (mu_of_flat !== e.mu)
                    begin
                        $error("mu_of_flat exp %0d got %0d", e.mu, mu_of_flat);
                        fail_count++;
                    end
                    if (species_of_flat !== e.sp)
                    begin
                        $error("species_of_flat exp %0d got %0d", e.sp, species_of_flat);
                        fail_count++;
                    end
                    if (flat_of_coords !== e.flat)
                    begin
                        $error("flat_of_coords exp %0d got %0d", e.flat, flat_of_coords);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic coord_in_t rand_coords(bit wild);
        coord_in_t c;
        longint unsigned span;
        span = longint'(size_of(lim_pkg::DIM_Y)) * size_of(lim_pkg::DIM_X)
               * size_of(lim_pkg::DIM_MU)
               * clamp_count(mdl_ns, lim_pkg::MAX_SPECIES);
        if (wild || $urandom_range(3) == 0)
        begin
            c.flat = 34'({$urandom, $urandom});
            c.y  = 11'($urandom);
            c.x  = 11'($urandom);
            c.mu = 11'($urandom);
            c.sp = 5'($urandom);
        end
        else
        begin
            c.flat = 34'(mdl_lower + ({$urandom, $urandom} % (span * 2)));
            c.y  = 11'($urandom_range(32'(size_of(lim_pkg::DIM_Y)), 1));
            c.x  = 11'($urandom_range(32'(size_of(lim_pkg::DIM_X)), 1));
            c.mu = 11'($urandom_range(32'(size_of(lim_pkg::DIM_MU)), 1));
            c.sp = 5'($urandom_range(32'(clamp_count(mdl_ns, lim_pkg::MAX_SPECIES)), 1));
        end
        return c;
    endfunction

    function automatic dir_row_t mk_row(logic [33:0] f, logic [10:0] y, logic [10:0] x,
                                        logic [10:0] m, logic [4:0] s, bit typed,
                                        logic [10:0] oy, logic [10:0] om,
                                        logic [4:0] os, logic [33:0] of);
        dir_row_t r;
        r.stim = '{f, y, x, m, s};
        r.typed = typed;
        r.want = '{oy, om, os, of};
        return r;
    endfunction

    initial
    begin
        coord_out_t none;
        int         phase_idle[4][2];
        none = '{11'd0, 11'd0, 5'd0, 34'd0};
        phase_idle = '{'{0, 0}, '{64, 0}, '{0, 64}, '{19, 19}};
        mdl_layout = lim_pkg::LAYOUT_YXMS;
        mdl_lower = '0;
        mdl_ny = 1; mdl_nx = 1; mdl_nmu = 1; mdl_ns = 1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset values: all sizes one
        dir_rows.push_back(mk_row(34'd0, 11'd1, 11'd1, 11'd1, 5'd1, 1,
                                  11'd1, 11'd1, 5'd1, 34'd0));
        dir_rows.push_back(mk_row(34'h3_FFFF_FFFF, 11'd1, 11'd1, 11'd1, 5'd1, 1,
                                  11'd1, 11'd1, 5'd1, 34'd0));
        dir_rows.push_back(mk_row(34'd5, 11'd0, 11'd1, 11'd1, 5'd1, 1,
                                  11'd1, 11'd1, 5'd1, 34'h3_FFFF_FFFF));
        dir_rows.push_back(mk_row(34'd7, 11'h7FF, 11'h7FF, 11'h7FF, 5'h1F, 0,
                                  0, 0, 0, 0));
        foreach (dir_rows[i])
            send_coords(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
        drain_results();

        // Every layout at largest sizes, then zero and oversized counts
        for (int l = 0; l < 8; l++)
        begin
            write_all(l[2:0], 34'(l * 1000), 11'd1024, 11'd1024, 11'd1024, 5'd16);
            send_coords('{34'h3_FFFF_FFFF, 11'd1024, 11'd1024, 11'd1024, 5'd16}, 0, none);
            send_coords('{34'd0, 11'd1, 11'd1, 11'd1, 5'd1}, 0, none);
            send_coords('{34'(l * 1000 + 12345), 11'd0, 11'd2000, 11'd3, 5'd0}, 0, none);
            drain_results();
        end
        write_all(lim_pkg::LAYOUT_YMXS, 34'h3_FFFF_FFFF, 11'd0, 11'h7FF, 11'd0, 5'h1F);
        send_coords('{34'd100, 11'd2, 11'd5, 11'd1, 5'd3}, 0, none);
        send_coords('{34'h3_FFFF_FFFE, 11'd1, 11'd1, 11'd1, 5'd1}, 0, none);
        drain_results();

        // Random phases over random settings
        for (int p = 0; p < 15; p++)
        begin
            send_idle  = phase_idle[p % 4][0];
            recv_stall = phase_idle[p % 4][1];
            if (p % 5 == 4)
                write_all(3'($urandom), 34'({$urandom, $urandom}), 11'($urandom),
                          11'($urandom), 11'($urandom), 5'($urandom));
            else
                write_all(3'($urandom_range(5)), 34'({$urandom, $urandom}),
                          11'($urandom_range(12, 1)), 11'($urandom_range(12, 1)),
                          11'($urandom_range(12, 1)), 5'($urandom_range(16, 1)));
            for (int i = 0; i < N_RANDOM / 15; i++)
                send_coords(rand_coords(p % 5 == 4), 0, none);
            drain_results();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[layout_index_map_unit.f]
design/lim_pkg.sv
design/lim_cfg.sv
design/lim_cell.sv
design/layout_index_map_unit.sv
sim/tb_layout_index_map_unit.sv
